// ===== rtl/spal_pkg.sv =====
package spal_pkg;

	localparam int MAX_DIM     = 64;
	localparam int FRAC_BITS   = 12;
	localparam int QUEUE_DEPTH = 2;
	localparam int RATE_ONE    = 4096;
	localparam int DIM_RESET   = 64;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_LEARN_MODE    = 2'd0;
	localparam logic [1:0] CFG_DIM_IN_USE    = 2'd1;
	localparam logic [1:0] CFG_LEARNING_RATE = 2'd2;
	localparam logic [1:0] CFG_WEIGHT_DECAY  = 2'd3;

	typedef enum logic {
		OP_TABLE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// one classified word handed from the front to the back
	typedef struct packed {
		op_t                op;
		logic [5:0]         entry;
		logic [5:0]         source;
		logic               sign;
		logic signed [15:0] scale;
		logic signed [15:0] bias;
		logic signed [15:0] sample;
		logic signed [15:0] target;
		logic [5:0]         pos;
		logic               last;
	} cmd_t;

	// effective settings seen by the back end
	typedef struct packed {
		logic               learn;
		logic [6:0]         dim;
		logic [12:0]        rate;
		logic signed [15:0] decay;
	} cfg_t;

endpackage

// ===== rtl/spal_queue.sv =====
module spal_queue #(
	parameter int DEPTH = spal_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  spal_pkg::cmd_t push_data,
	input  logic          pop,
	output spal_pkg::cmd_t pop_data,
	output logic          full,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	spal_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// store word
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/spal_front.sv =====
module spal_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               operation,
	input  logic [5:0]         entry_index,
	input  logic [5:0]         perm_source,
	input  logic               sign_negative,
	input  logic signed [15:0] scale_value,
	input  logic signed [15:0] bias_value,
	input  logic signed [15:0] sample_value,
	input  logic signed [15:0] target_value,
	input  logic [6:0]         dim,
	output logic               push,
	output spal_pkg::cmd_t     cmd
);

	logic [6:0] fill_q;
	logic       is_last;

	assign push    = start && !busy;
	assign is_last = ((fill_q + 7'd1) >= dim);

	// classify word and tag vector position
	always_comb begin
		cmd.op     = spal_pkg::op_t'(operation);
		cmd.entry  = entry_index;
		cmd.source = perm_source;
		cmd.sign   = sign_negative;
		cmd.scale  = scale_value;
		cmd.bias   = bias_value;
		cmd.sample = sample_value;
		cmd.target = target_value;
		cmd.pos    = fill_q[5:0];
		cmd.last   = is_last;
	end

	// count vector elements, wrap on the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push && (spal_pkg::op_t'(operation) == spal_pkg::OP_SAMPLE)) begin
			fill_q <= is_last ? 7'd0 : fill_q + 7'd1;
		end
	end

endmodule

// ===== rtl/spal_back.sv =====
module spal_back #(
	parameter int MAX_DIM   = spal_pkg::MAX_DIM,
	parameter int FRAC_BITS = spal_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spal_pkg::cmd_t     cmd,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  spal_pkg::cfg_t     cfg,
	output logic               strobe,
	output logic [5:0]         out_index,
	output logic signed [15:0] out_value,
	output logic               saturated,
	output logic               last_result
);

	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int F  = FRAC_BITS;
	localparam int SW = 35;
	localparam int PW = SW - F;
	localparam int EW = PW + 1;
	localparam int DW = EW + 18;
	localparam int HW = DW - 24;
	localparam int TW = DW + 15;
	localparam int RS = F + 12;
	localparam int LIM_HI = ((4 << F) > 32767) ? 32767 : (4 << F);
	localparam int LIM_LO = ((4 << F) > 32768) ? -32768 : -(4 << F);

	typedef struct packed {
		logic [5:0]         perm;
		logic               sign;
		logic signed [15:0] scale;
		logic signed [15:0] bias;
	} row_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_X, S_MUL, S_PRED, S_LEX, S_LWS, S_LWB, S_LDB, S_LRB,
		S_LSUM, S_LWR
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      idx_q;

	row_t               tbl_mem_q [MAX_DIM];
	logic [MAX_DIM-1:0] tbl_vld_q;
	logic signed [15:0] in_mem_q  [MAX_DIM];
	logic signed [15:0] tgt_mem_q [MAX_DIM];

	row_t               row_rd_q;
	logic               vld_rd_q;
	logic signed [15:0] tgt_rd_q;
	logic signed [15:0] in_rd_q;

	row_t               cur_q;
	logic signed [16:0] x_q;
	logic signed [32:0] prod_q;
	logic signed [PW-1:0] pred_q;
	logic signed [EW-1:0] err_q;
	logic signed [DW-1:0] ex_q;
	logic signed [31:0] wsc_q;
	logic signed [31:0] wbi_q;
	logic signed [DW-1:0] ds_q;
	logic signed [DW-1:0] db_q;
	logic signed [HW+13:0] rh_q;
	logic [36:0]        rl_q;
	logic signed [TW-1:0] dsel_q;
	logic signed [TW-1:0] dbel_q;
	logic signed [15:0] nsc_q;

	logic               strobe_q;
	logic [5:0]         out_index_q;
	logic signed [15:0] out_value_q;
	logic               saturated_q;
	logic               last_q;

	row_t               row_eff;
	logic [AW-1:0]      p_addr;
	logic signed [16:0] x_n;
	logic signed [SW-1:0] sum_n;
	logic signed [PW-1:0] pred_n;
	logic               sat_n;
	logic signed [15:0] val_n;
	logic signed [EW-1:0] err_n;
	logic signed [DW-1:0] mul_op;
	logic signed [TW-1:0] ts_n;
	logic signed [TW-1:0] del_n;
	logic signed [15:0] nbi_n;
	logic [6:0]         dlast;
	logic               at_end;
	logic               tbl_we;
	logic [AW-1:0]      tbl_wa;
	row_t               tbl_wd;
	logic               pop_tbl;
	logic               pop_smp;

	function automatic logic signed [15:0] clamp4(input logic signed [TW-1:0] v);
		if (v > TW'(LIM_HI)) begin
			return 16'(LIM_HI);
		end else if (v < TW'(LIM_LO)) begin
			return 16'(LIM_LO);
		end
		return v[15:0];
	endfunction

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign pop_tbl = cmd_pop && (cmd.op == spal_pkg::OP_TABLE)
		&& ({1'b0, cmd.entry} < 7'(MAX_DIM));
	assign pop_smp = cmd_pop && (cmd.op == spal_pkg::OP_SAMPLE);
	assign dlast   = cfg.dim - 7'd1;
	assign at_end  = (7'(idx_q) == dlast);

	// fall back to reset contents for rows never written
	always_comb begin
		if (vld_rd_q) begin
			row_eff = row_rd_q;
		end else begin
			row_eff.perm  = 6'(idx_q);
			row_eff.sign  = 1'b0;
			row_eff.scale = 16'(1 << F);
			row_eff.bias  = '0;
		end
		p_addr = row_eff.perm[AW-1:0];
	end

	// signed source element and prediction
	always_comb begin
		if ({1'b0, cur_q.perm} < cfg.dim) begin
			x_n = cur_q.sign ? -17'(in_rd_q) : 17'(in_rd_q);
		end else begin
			x_n = '0;
		end
		sum_n  = SW'(prod_q) + (SW'(cur_q.bias) <<< F) + SW'(1 << (F - 1));
		pred_n = sum_n[SW-1:F];
		sat_n  = (pred_n > PW'(32767)) || (pred_n < PW'(-32768));
		if (pred_n > PW'(32767)) begin
			val_n = 16'sd32767;
		end else if (pred_n < PW'(-32768)) begin
			val_n = -16'sd32768;
		end else begin
			val_n = pred_n[15:0];
		end
		err_n = EW'(tgt_rd_q) - EW'(pred_q);
	end

	// rate product over split partials, rounded back to the data scale
	always_comb begin
		mul_op = (state_q == S_LDB) ? ds_q : db_q;
		ts_n   = (TW'(rh_q) <<< 24) + TW'(signed'({1'b0, rl_q}))
			+ TW'(64'(1) << (RS - 1));
		del_n  = ts_n >>> RS;
		nbi_n  = clamp4(TW'(cur_q.bias) + dbel_q);
	end

	// table write port: loads from the queue and learned updates
	always_comb begin
		tbl_we = pop_tbl || (state_q == S_LWR);
		if (state_q == S_LWR) begin
			tbl_wa       = idx_q;
			tbl_wd.perm  = cur_q.perm;
			tbl_wd.sign  = cur_q.sign;
			tbl_wd.scale = nsc_q;
			tbl_wd.bias  = nbi_n;
		end else begin
			tbl_wa       = cmd.entry[AW-1:0];
			tbl_wd.perm  = cmd.source;
			tbl_wd.sign  = cmd.sign;
			tbl_wd.scale = cmd.scale;
			tbl_wd.bias  = cmd.bias;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem_q[tbl_wa] <= tbl_wd;
		end
		row_rd_q <= tbl_mem_q[idx_q];
		vld_rd_q <= tbl_vld_q[idx_q];
	end

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (tbl_we) begin
			tbl_vld_q[tbl_wa] <= 1'b1;
		end
	end

	// sample and target buffers
	always_ff @(posedge clk) begin
		if (pop_smp) begin
			in_mem_q[cmd.pos[AW-1:0]]  <= cmd.sample;
			tgt_mem_q[cmd.pos[AW-1:0]] <= cmd.target;
		end
		in_rd_q  <= in_mem_q[p_addr];
		tgt_rd_q <= tgt_mem_q[idx_q];
	end

	// walk sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop_smp && cmd.last) begin
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_X;
				end
				S_X: begin
					cur_q   <= row_eff;
					state_q <= S_MUL;
				end
				S_MUL: begin
					x_q     <= x_n;
					prod_q  <= 33'(cur_q.scale * x_n);
					state_q <= S_PRED;
				end
				S_PRED: begin
					pred_q      <= pred_n;
					strobe_q    <= 1'b1;
					out_index_q <= 6'(idx_q);
					out_value_q <= val_n;
					saturated_q <= sat_n;
					last_q      <= at_end;
					if (cfg.learn) begin
						state_q <= S_LEX;
					end else if (at_end) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_LEX: begin
					err_q   <= err_n;
					ex_q    <= DW'(err_n * x_q);
					state_q <= S_LWS;
				end
				S_LWS: begin
					wsc_q   <= cfg.decay * cur_q.scale;
					state_q <= S_LWB;
				end
				S_LWB: begin
					wbi_q   <= cfg.decay * cur_q.bias;
					ds_q    <= ex_q - DW'(wsc_q);
					state_q <= S_LDB;
				end
				S_LDB: begin
					db_q    <= (DW'(err_q) <<< F) - DW'(wbi_q);
					rh_q    <= signed'({1'b0, cfg.rate}) * signed'(mul_op[DW-1:24]);
					rl_q    <= cfg.rate * mul_op[23:0];
					state_q <= S_LRB;
				end
				S_LRB: begin
					dsel_q  <= del_n;
					rh_q    <= signed'({1'b0, cfg.rate}) * signed'(mul_op[DW-1:24]);
					rl_q    <= cfg.rate * mul_op[23:0];
					state_q <= S_LSUM;
				end
				S_LSUM: begin
					dbel_q  <= del_n;
					nsc_q   <= clamp4(TW'(cur_q.scale) + dsel_q);
					state_q <= S_LWR;
				end
				S_LWR: begin
					if (at_end) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign out_index   = out_index_q;
	assign out_value   = out_value_q;
	assign saturated   = saturated_q;
	assign last_result = last_q;

endmodule

// ===== rtl/signed_permutation_affine_lms.sv =====
// Signed permutation affine map with delta-rule learning.
// Input channel: a word is taken at a clock edge where start is high and busy
// is low. operation 0 loads one table entry (source, sign, scale, bias);
// operation 1 appends one sample and one target element. Table loads and
// element appends are dequeued only while the back end is idle.
// When dim_in_use elements have arrived the back end walks the entries and
// emits one result per entry on out_* with strobe high for one cycle;
// last_result marks the final entry. Each entry is handled by a per-entry
// sequencer (read, operand, multiply, prediction, then the learning states in
// learn mode) sharing one table port and the multipliers. A two-word queue
// lets new words be taken during a walk; busy rises when it is full.
// Results cannot be held off: each is valid for exactly one cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// when the block is idle. cfg_ready is always high.
// Reset clears the queue, fill count and sequencer, restores the table to
// identity, positive sign, unit scale and zero bias, and sets the registers
// to their defaults.
module signed_permutation_affine_lms #(
	parameter int MAX_DIM   = spal_pkg::MAX_DIM,
	parameter int FRAC_BITS = spal_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [5:0]         entry_index,
	input  logic [5:0]         perm_source,
	input  logic               sign_negative,
	input  logic signed [15:0] scale_value,
	input  logic signed [15:0] bias_value,
	input  logic signed [15:0] sample_value,
	input  logic signed [15:0] target_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               strobe,
	output logic [5:0]         out_index,
	output logic signed [15:0] out_value,
	output logic               saturated,
	output logic               last_result
);

	logic               learn_q;
	logic [6:0]         dim_q;
	logic [12:0]        rate_q;
	logic signed [15:0] decay_q;
	spal_pkg::cfg_t     cfg;
	spal_pkg::cmd_t     push_cmd;
	spal_pkg::cmd_t     pop_cmd;
	logic               push;
	logic               pop;
	logic               empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q <= 1'b0;
			dim_q   <= 7'(spal_pkg::DIM_RESET);
			rate_q  <= '0;
			decay_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spal_pkg::CFG_LEARN_MODE:    learn_q <= cfg_data[0];
				spal_pkg::CFG_DIM_IN_USE:    dim_q   <= cfg_data[6:0];
				spal_pkg::CFG_LEARNING_RATE: rate_q  <= cfg_data[12:0];
				spal_pkg::CFG_WEIGHT_DECAY:  decay_q <= cfg_data;
				default:                     learn_q <= learn_q;
			endcase
		end
	end

	// limit length and rate to their working range
	always_comb begin
		cfg.learn = learn_q;
		if (dim_q == '0) begin
			cfg.dim = 7'd1;
		end else if (dim_q > 7'(MAX_DIM)) begin
			cfg.dim = 7'(MAX_DIM);
		end else begin
			cfg.dim = dim_q;
		end
		cfg.rate  = (rate_q > 13'(spal_pkg::RATE_ONE)) ? 13'(spal_pkg::RATE_ONE) : rate_q;
		cfg.decay = decay_q;
	end

	spal_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.entry_index   (entry_index),
		.perm_source   (perm_source),
		.sign_negative (sign_negative),
		.scale_value   (scale_value),
		.bias_value    (bias_value),
		.sample_value  (sample_value),
		.target_value  (target_value),
		.dim           (cfg.dim),
		.push          (push),
		.cmd           (push_cmd)
	);

	spal_queue #(
		.DEPTH (spal_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.full      (busy),
		.empty     (empty)
	);

	spal_back #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (pop_cmd),
		.cmd_valid   (!empty),
		.cmd_pop     (pop),
		.cfg         (cfg),
		.strobe      (strobe),
		.out_index   (out_index),
		.out_value   (out_value),
		.saturated   (saturated),
		.last_result (last_result)
	);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import spal_pkg::*;

	// one expected output element
	typedef struct {
		logic [5:0]         idx;
		logic signed [15:0] val;
		logic               sat;
		logic               last;
	} elem_t;

	// one stimulus word, with an optional typed-in output value
	typedef struct {
		op_t                op;
		logic [5:0]         entry;
		logic [5:0]         source;
		logic               sign;
		logic signed [15:0] scale;
		logic signed [15:0] bias;
		logic signed [15:0] sample;
		logic signed [15:0] target;
		bit                 typed;
		logic signed [15:0] want_val;
		logic               want_sat;
	} word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               operation = 1'b0;
	logic [5:0]         entry_index = '0;
	logic [5:0]         perm_source = '0;
	logic               sign_negative = 1'b0;
	logic signed [15:0] scale_value = '0;
	logic signed [15:0] bias_value = '0;
	logic signed [15:0] sample_value = '0;
	logic signed [15:0] target_value = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               strobe;
	logic [5:0]         out_index;
	logic signed [15:0] out_value;
	logic               saturated;
	logic               last_result;

	// shadow copy of the block state
	logic [5:0]         perm_sh [MAX_DIM];
	logic               sign_sh [MAX_DIM];
	longint             scale_sh [MAX_DIM];
	longint             bias_sh [MAX_DIM];
	longint             samp_buf [MAX_DIM];
	longint             targ_buf [MAX_DIM];
	int                 fill_sh;
	logic               learn_sh;
	logic [6:0]         dim_sh;
	logic [12:0]        rate_sh;
	logic signed [15:0] decay_sh;

	elem_t  pending_elems[$];
	int     errors = 0;
	int     idle_pct = 0;
	word_t  directed[$];

	signed_permutation_affine_lms uut (.*);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint rnd_q12(input longint v);
		return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// advance the shadow state by one accepted word and queue its output elements
	task automatic predict_word(input word_t w);
		int     d;
		longint rate, x, pred, v, err, ds, db;
		elem_t  e;
		if (w.op == OP_TABLE) begin
			perm_sh[w.entry]  = w.source;
			sign_sh[w.entry]  = w.sign;
			scale_sh[w.entry] = w.scale;
			bias_sh[w.entry]  = w.bias;
			return;
		end
		d = dim_sh == 0 ? 1 : (dim_sh > MAX_DIM ? MAX_DIM : dim_sh);
		if (fill_sh < MAX_DIM) begin
			samp_buf[fill_sh] = w.sample;
			targ_buf[fill_sh] = w.target;
		end
		fill_sh++;
		if (fill_sh < d)
			return;
		fill_sh = 0;
		rate = rate_sh > RATE_ONE ? RATE_ONE : rate_sh;
		for (int i = 0; i < d; i++) begin
			x = perm_sh[i] < d ? samp_buf[perm_sh[i]] : 0;
			if (sign_sh[i])
				x = -x;
			pred = rnd_q12(scale_sh[i] * x + (bias_sh[i] <<< FRAC_BITS));
			v = clip(pred, -32768, 32767);
			e.idx  = i[5:0];
			e.val  = v[15:0];
			e.sat  = v != pred;
			e.last = (i + 1 == d);
			if (w.typed) begin
				e.val = w.want_val;
				e.sat = w.want_sat;
			end
			pending_elems.push_back(e);
			if (learn_sh) begin
				err = targ_buf[i] - pred;
				ds = err * x - longint'(decay_sh) * scale_sh[i];
				db = (err <<< FRAC_BITS) - longint'(decay_sh) * bias_sh[i];
				scale_sh[i] = clip(scale_sh[i] + ((rate * ds + (64'sd1 <<< 23)) >>> 24),
					-16384, 16384);
				bias_sh[i] = clip(bias_sh[i] + ((rate * db + (64'sd1 <<< 23)) >>> 24),
					-16384, 16384);
			end
		end
	endtask

	// hand one word over, holding start until the block takes it
	task automatic send_word(input word_t w);
		bit taken;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start         <= 1'b1;
		operation     <= w.op;
		entry_index   <= w.entry;
		perm_source   <= w.source;
		sign_negative <= w.sign;
		scale_value   <= w.scale;
		bias_value    <= w.bias;
		sample_value  <= w.sample;
		target_value  <= w.target;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		predict_word(w);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LEARN_MODE:    learn_sh = data[0];
			CFG_DIM_IN_USE:    dim_sh   = data[6:0];
			CFG_LEARNING_RATE: rate_sh  = data[12:0];
			default:           decay_sh = data;
		endcase
	endtask

	// drain all outputs, then let trailing table loads settle
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_elems.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic word_t tbl(input logic [5:0] en, input logic [5:0] src,
			input logic sg, input logic signed [15:0] sc, input logic signed [15:0] bi);
		word_t w;
		w = '{OP_TABLE, en, src, sg, sc, bi, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0};
		return w;
	endfunction

	function automatic word_t smp(input logic signed [15:0] s, input logic signed [15:0] t,
			input bit ty, input logic signed [15:0] wv, input logic ws);
		word_t w;
		w = '{OP_SAMPLE, 6'd0, 6'd0, 1'b0, 16'sd0, 16'sd0, s, t, ty, wv, ws};
		return w;
	endfunction

	function automatic logic signed [15:0] rnd_val();
		return $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16384) - 8192);
	endfunction

	// check each output element against the oldest expectation
	always @(negedge clk) begin
		elem_t e;
		if (arst_n && strobe) begin
			if (pending_elems.size() == 0) begin
				report_mismatch($sformatf("unexpected element idx=%0d val=%0d",
					out_index, out_value));
			end else begin
				e = pending_elems.pop_front();
				if (out_index !== e.idx || out_value !== e.val ||
						saturated !== e.sat || last_result !== e.last)
					report_mismatch($sformatf(
						"idx %0d/%0d val %0d/%0d sat %0b/%0b last %0b/%0b (got/exp)",
						out_index, e.idx, out_value, e.val, saturated, e.sat,
						last_result, e.last));
			end
		end
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		word_t w;
		int    n_items;
		int    d;
		for (int i = 0; i < MAX_DIM; i++) begin
			perm_sh[i]  = i[5:0];
			sign_sh[i]  = 1'b0;
			scale_sh[i] = 1 <<< FRAC_BITS;
			bias_sh[i]  = 0;
			samp_buf[i] = 0;
			targ_buf[i] = 0;
		end
		fill_sh  = 0;
		learn_sh = 1'b0;
		dim_sh   = DIM_RESET;
		rate_sh  = '0;
		decay_sh = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: one-element vectors, extremes, sign, saturation, out-of-range source
		write_reg(CFG_DIM_IN_USE, 16'd1);
		directed.push_back(smp(16'sd32767, 16'sd0, 1, 16'sd32767, 1'b0));
		directed.push_back(smp(-16'sd32768, 16'sd0, 1, -16'sd32768, 1'b0));
		directed.push_back(tbl(6'd0, 6'd0, 1'b1, 16'sd4096, 16'sd0));
		directed.push_back(smp(-16'sd32768, 16'sd0, 1, 16'sd32767, 1'b1));
		directed.push_back(tbl(6'd0, 6'd0, 1'b0, 16'sd32767, 16'sd32767));
		directed.push_back(smp(16'sd32767, 16'sd0, 1, 16'sd32767, 1'b1));
		directed.push_back(tbl(6'd0, 6'd0, 1'b0, -16'sd32768, -16'sd32768));
		directed.push_back(smp(16'sd32767, 16'sd0, 1, -16'sd32768, 1'b1));
		directed.push_back(tbl(6'd0, 6'd63, 1'b1, 16'sd4096, 16'sd100));
		directed.push_back(smp(16'sd1000, 16'sd0, 1, 16'sd100, 1'b0));
		directed.push_back(tbl(6'd63, 6'd63, 1'b1, -16'sd1, 16'sd1));
		directed.push_back(tbl(6'd0, 6'd0, 1'b0, 16'sd4096, 16'sd0));
		directed.push_back(smp(16'sd0, 16'sd0, 1, 16'sd0, 1'b0));
		directed.push_back(smp(16'sd3, -16'sd3, 0, 16'sd0, 1'b0));
		foreach (directed[i])
			send_word(directed[i]);
		wait_drained();

		// learn twice at full rate with extreme decay, then once at above-one rate
		write_reg(CFG_LEARN_MODE, 16'd1);
		write_reg(CFG_LEARNING_RATE, 16'd4096);
		write_reg(CFG_WEIGHT_DECAY, 16'h8000);
		send_word(smp(16'sd32767, -16'sd32768, 0, 16'sd0, 1'b0));
		send_word(smp(-16'sd32768, 16'sd32767, 0, 16'sd0, 1'b0));
		wait_drained();
		write_reg(CFG_LEARNING_RATE, 16'h1FFF);
		write_reg(CFG_WEIGHT_DECAY, 16'h7FFF);
		send_word(smp(16'sd1234, 16'sd32767, 0, 16'sd0, 1'b0));
		wait_drained();

		// random phases with changing settings and idling
		n_items = 0;
		for (int ph = 0; n_items < 450; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 66;
				2: idle_pct = 24;
				default: idle_pct = $urandom_range(1) ? 0 : 50;
			endcase
			case ($urandom_range(9))
				0: d = 64;
				1: d = 0;
				2: d = 100;
				3: d = 127;
				default: d = $urandom_range(1, 8);
			endcase
			write_reg(CFG_DIM_IN_USE, 16'(d));
			write_reg(CFG_LEARN_MODE, 16'($urandom_range(1)));
			case ($urandom_range(3))
				0: write_reg(CFG_LEARNING_RATE, 16'd0);
				1: write_reg(CFG_LEARNING_RATE, 16'd4096);
				2: write_reg(CFG_LEARNING_RATE, 16'h1FFF);
				default: write_reg(CFG_LEARNING_RATE, 16'($urandom_range(4096)));
			endcase
			write_reg(CFG_WEIGHT_DECAY, $urandom_range(1) ? 16'($urandom) :
				16'($urandom_range(256)));
			d = dim_sh == 0 ? 1 : (dim_sh > MAX_DIM ? MAX_DIM : dim_sh);
			for (int k = 0; k < (d > 16 ? 2 * d + 4 : 40); k++) begin
				if ($urandom_range(99) < 20) begin
					w = tbl(6'($urandom), $urandom_range(99) < 80 ?
						6'($urandom_range(d - 1)) : 6'($urandom),
						1'($urandom), rnd_val(), rnd_val());
				end else begin
					w = smp(rnd_val(), rnd_val(), 0, 16'sd0, 1'b0);
				end
				send_word(w);
				n_items++;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
